@@ design/iids_pkg.sv @@
`default_nettype none

package iids_pkg;

  localparam int DEPTH = 128;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_DEL,
    SH_INS
  } shift_op_t;

  // cell k holds entry count-1-k, so cell 0 is always the top
  typedef struct packed {
    shift_op_t        op;
    logic [CNT_W-1:0] pivot;
    logic [7:0]       data;
  } shift_ctl_t;

endpackage

`default_nettype wire

@@ design/iids_if.sv @@
`default_nettype none

interface iids_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [6:0] position;
  logic [7:0] data_byte;

  modport source (output valid, cmd, position, data_byte, input ready);
  modport sink   (input valid, cmd, position, data_byte, output ready);
endinterface

interface iids_resp_if;
  logic       valid;
  logic       ready;
  logic [7:0] top_byte;
  logic [7:0] entry_count;
  logic       accepted;

  modport source (output valid, top_byte, entry_count, accepted, input ready);
  modport sink   (input valid, top_byte, entry_count, accepted, output ready);
endinterface

`default_nettype wire

@@ design/iids_cell.sv @@
`default_nettype none

module iids_cell import iids_pkg::*; (
  input  wire logic             clk,
  input  wire shift_ctl_t       ctl,
  input  wire logic [CNT_W-1:0] idx,
  input  wire logic [7:0]       from_prev,
  input  wire logic [7:0]       from_next,
  output logic      [7:0]       value
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      SH_DEL: begin
        if (idx >= ctl.pivot) begin
          value <= from_next;
        end
      end
      SH_INS: begin
        if (idx == ctl.pivot) begin
          value <= ctl.data;
        end else if (idx > ctl.pivot) begin
          value <= from_prev;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/indexed_insert_delete_stack_core.sv @@
// Byte stack with positional insert and delete.
// Channels: req carries cmd (push, pop, delete at, insert at), position and
// data_byte; rsp returns top_byte, entry_count and accepted, one response
// per command, in order. Both use valid/ready; a transfer happens when
// valid and ready are high at a rising edge of clk.
// The response is valid the cycle after the command transfer.
// Throughput: one command per cycle while rsp is not stalled. Every entry sits
// in its own cell that keeps, takes a neighbor or loads the new byte, so all
// cells update together on each accepted command.
// The response register frees the input side: req.ready is high while the
// response register is empty or being taken this cycle. When rsp is stalled
// the pending response holds and req.ready drops after that one command.
// Reset (rst, synchronous) empties the stack and the response register;
// stored bytes are not cleared, only entries below the count are ever read.
// Rejected commands (full, empty, bad index) change nothing and report
// accepted = 0 with the current top and count.
`default_nettype none

module indexed_insert_delete_stack_core import iids_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  iids_cmd_if.sink   req,
  iids_resp_if.source rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [7:0]       vals [DEPTH];
  logic [7:0]       top_next;
  logic             ok;
  logic             xfer;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] pivot_w;
  shift_ctl_t       ctl;

  logic             out_valid;
  logic [7:0]       out_top;
  logic [7:0]       out_count;
  logic             out_ok;

  assign req.ready = !out_valid || rsp.ready;
  assign xfer      = req.valid && req.ready;
  assign pos_w     = CMP_W'(req.position);
  assign cnt_w     = CMP_W'(count);

  always_comb begin
    ok      = 1'b0;
    pivot_w = '0;
    case (cmd_t'(req.cmd))
      CMD_PUSH: begin
        ok      = cnt_w < DEPTH_C;
        pivot_w = '0;
      end
      CMD_POP: begin
        ok      = cnt_w != '0;
        pivot_w = '0;
      end
      CMD_DELETE: begin
        ok      = pos_w < cnt_w;
        pivot_w = cnt_w - pos_w - CMP_W'(1);
      end
      CMD_INSERT: begin
        ok      = (pos_w <= cnt_w) && (cnt_w < DEPTH_C);
        pivot_w = cnt_w - pos_w;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.pivot = pivot_w[CNT_W-1:0];
    ctl.data  = req.data_byte;
    ctl.op    = SH_NONE;
    if (xfer && ok) begin
      if (req.cmd == CMD_POP || req.cmd == CMD_DELETE) begin
        ctl.op = SH_DEL;
      end else begin
        ctl.op = SH_INS;
      end
    end
  end

  always_comb begin
    count_next = count;
    top_next   = vals[0];
    case (ctl.op)
      SH_DEL: begin
        count_next = count - CNT_W'(1);
        if (ctl.pivot == '0) begin
          top_next = vals[1];
        end
      end
      SH_INS: begin
        count_next = count + CNT_W'(1);
        if (ctl.pivot == '0) begin
          top_next = ctl.data;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [7:0] prev_v;
    logic [7:0] next_v;
    if (k == 0) begin : g_first
      assign prev_v = 8'd0;
    end else begin : g_prev
      assign prev_v = vals[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_v = 8'd0;
    end else begin : g_next
      assign next_v = vals[k+1];
    end
    iids_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (CNT_W'(k)),
      .from_prev (prev_v),
      .from_next (next_v),
      .value     (vals[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (xfer) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_top   <= (count_next == '0) ? 8'd0 : top_next;
      out_count <= 8'(count_next);
      out_ok    <= ok;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.top_byte    = out_top;
  assign rsp.entry_count = out_count;
  assign rsp.accepted    = out_ok;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= DEPTH_C)
    else $error("count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    xfer && req.cmd == CMD_PUSH && ok |=> count == $past(count) + CNT_W'(1))
    else $error("accepted push did not raise count");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    xfer && !ok |=> $stable(count))
    else $error("rejected command changed count");

  a_resp_count: assert property (@(posedge clk) disable iff (rst)
    xfer |=> out_count == 8'(count))
    else $error("response count disagrees with stack count");
`endif

endmodule

`default_nettype wire
